### rtl/core/mpf_pkg.sv
// Package: shared types, constants and controller states of the minutiae proximity filter.
package mpf_pkg;

  localparam int MAX_MINUTIAE_DEF = 32;
  localparam int COORD_W          = 10;
  localparam int DSQ_W            = 21;
  localparam int REMOVED_W        = 6;
  localparam int CFG_ADDR_W       = 3;
  localparam int CFG_DATA_W       = 32;
  localparam logic [DSQ_W-1:0] MIN_DIST_SQ_RST = 21'd100;
  localparam logic             REG_MIN_DIST_SQ = 1'b0;

  typedef struct packed {
    logic [COORD_W-1:0] loc_x;
    logic [COORD_W-1:0] loc_y;
    logic               is_bifurcation;
    logic               last_in_set;
  } mpf_in_t;

  typedef struct packed {
    logic                 result_kind;
    logic [COORD_W-1:0]   out_x;
    logic [COORD_W-1:0]   out_y;
    logic                 out_bifurcation;
    logic                 centroid_valid;
    logic [REMOVED_W-1:0] removed_count;
    logic                 last_result;
  } mpf_out_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               bif;
  } mpf_entry_t;

  typedef struct packed {
    logic init;
    logic load;
    logic pair_run;
    logic emit_run;
    logic div_go;
    logic div_sel_y;
    logic latch_q;
    logic send_centroid;
  } mpf_cmd_t;

  typedef struct packed {
    logic n_lt2;
    logic pair_last;
    logic emit_last;
    logic div_done;
  } mpf_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PAIR,
    ST_EMIT,
    ST_EMIT_DRAIN,
    ST_DIVX_GO,
    ST_DIVX_WAIT,
    ST_DIVY_GO,
    ST_DIVY_WAIT,
    ST_CENTROID
  } mpf_state_t;

endpackage

### rtl/core/minutiae_proximity_filter_top.sv
// Top level: minutiae proximity filter with register port, controller and datapath.
//
// Minutiae are loaded one per cycle while busy is low; an item past MAX_MINUTIAE
// held entries is dropped. The item with last_in_set raises busy, which stays high
// through the pair pass (one minutia pair per cycle through the dual-read minutia
// store), the emit pass (one entry per cycle), then the x and y centroid
// divisions, one bit per cycle on a shared divider. Results appear on out_data
// for a single cycle with out_valid high; the receiver cannot stall, so it must
// take every beat as it comes. Surviving minutiae arrive in load order, followed
// by the centroid beat with last_result set; busy falls in the cycle that carries
// that beat.
module minutiae_proximity_filter_top
  import mpf_pkg::*;
#(
  parameter int MAX_MINUTIAE = MAX_MINUTIAE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  mpf_in_t               in_data,
  output logic                  out_valid,
  output mpf_out_t              out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [DSQ_W-1:0] min_dist_sq_r;
  logic             cfg_hit;
  mpf_cmd_t         cmd;
  mpf_status_t      status;

  assign cfg_hit = paddr[CFG_ADDR_W-1] == REG_MIN_DIST_SQ;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dist_sq_r <= MIN_DIST_SQ_RST;
    end else if (psel && penable && pwrite && cfg_hit) begin
      min_dist_sq_r <= pwdata[DSQ_W-1:0];
    end
  end

  assign prdata = cfg_hit ? CFG_DATA_W'(min_dist_sq_r) : '0;

  mpf_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_last (in_data.last_in_set),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy)
  );

  mpf_datapath #(
    .MAX_MINUTIAE(MAX_MINUTIAE)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_data         (in_data),
    .min_distance_sq (min_dist_sq_r),
    .out_valid       (out_valid),
    .out_data        (out_data)
  );

endmodule

### rtl/core/mpf_divider.sv
// Restoring divider, one quotient bit per cycle.
module mpf_divider
  import mpf_pkg::*;
#(
  parameter int DW = 16,
  parameter int VW = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int KW = $clog2(DW + 1);

  logic [VW-1:0] rem_r;
  logic [VW-1:0] rem_nxt;
  logic [DW-1:0] q_r;
  logic [VW-1:0] divisor_r;
  logic [KW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;
  logic [VW:0]   rem_sh;
  logic [VW:0]   rem_diff;
  logic          fits;

  always_comb begin
    rem_sh   = {rem_r, q_r[DW-1]};
    rem_diff = rem_sh - {1'b0, divisor_r};
    fits     = rem_sh >= {1'b0, divisor_r};
    rem_nxt  = fits ? rem_diff[VW-1:0] : rem_sh[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !go && run_r && cnt_r == KW'(1);
      if (go) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == KW'(1)) begin
        run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r     <= '0;
      q_r       <= dividend;
      divisor_r <= divisor;
      cnt_r     <= KW'(DW);
    end else if (run_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[DW-2:0], fits};
      cnt_r <= cnt_r - KW'(1);
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

### rtl/core/mpf_datapath.sv
// Datapath: minutia store, pair distance check, marks, sums and result register.
module mpf_datapath
  import mpf_pkg::*;
#(
  parameter int MAX_MINUTIAE = MAX_MINUTIAE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  mpf_cmd_t         cmd,
  output mpf_status_t      status,
  input  mpf_in_t          in_data,
  input  logic [DSQ_W-1:0] min_distance_sq,
  output logic             out_valid,
  output mpf_out_t         out_data
);

  localparam int IW = $clog2(MAX_MINUTIAE);
  localparam int CW = $clog2(MAX_MINUTIAE + 1);
  localparam int SW = COORD_W + CW;

  mpf_entry_t mem [MAX_MINUTIAE];
  mpf_entry_t rd_a_r;
  mpf_entry_t rd_b_r;

  logic [CW-1:0]           n_r;
  logic [IW-1:0]           i_r;
  logic [IW-1:0]           j_r;
  logic [IW-1:0]           e_r;
  logic [IW-1:0]           addr_a;
  logic                    full;
  logic                    pv_r;
  logic [IW-1:0]           pi_r;
  logic [IW-1:0]           pj_r;
  logic                    ev_r;
  logic [IW-1:0]           ek_r;
  logic [MAX_MINUTIAE-1:0] mark_r;
  logic [MAX_MINUTIAE-1:0] mark_set;

  logic [SW-1:0] rid_sx_r;
  logic [SW-1:0] rid_sy_r;
  logic [SW-1:0] bif_sx_r;
  logic [SW-1:0] bif_sy_r;
  logic [CW-1:0] rid_n_r;
  logic [CW-1:0] bif_n_r;
  logic [CW-1:0] removed_r;

  logic [COORD_W-1:0] dx;
  logic [COORD_W-1:0] dy;
  logic [2*COORD_W-1:0] dx2;
  logic [2*COORD_W-1:0] dy2;
  logic [DSQ_W-1:0]   dsq;
  logic               close_pair;

  logic          use_bif;
  logic [CW-1:0] cnt;
  logic          cnt_nz;
  logic [SW-1:0] div_num;
  logic          div_done;
  logic [SW-1:0] div_q;
  logic [COORD_W-1:0] qx_r;
  logic [COORD_W-1:0] qy_r;

  logic     out_valid_r;
  mpf_out_t out_data_r;

  assign full   = n_r == CW'(MAX_MINUTIAE);
  assign addr_a = cmd.emit_run ? e_r : i_r;

  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      mem[n_r[IW-1:0]] <= '{x: in_data.loc_x, y: in_data.loc_y, bif: in_data.is_bifurcation};
    end
    rd_a_r <= mem[addr_a];
    rd_b_r <= mem[j_r];
  end

  always_comb begin
    status.n_lt2     = n_r < CW'(2);
    status.pair_last = (CW'(i_r) == n_r - CW'(2)) && (CW'(j_r) == n_r - CW'(1));
    status.emit_last = CW'(e_r) == n_r - CW'(1);
    status.div_done  = div_done;
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      i_r <= '0;
      j_r <= IW'(1);
      e_r <= '0;
    end else begin
      if (cmd.pair_run) begin
        if (CW'(j_r) == n_r - CW'(1)) begin
          i_r <= i_r + IW'(1);
          j_r <= IW'(i_r + 2'd2);
        end else begin
          j_r <= j_r + IW'(1);
        end
      end
      if (cmd.emit_run) begin
        e_r <= e_r + IW'(1);
      end
    end
    pi_r <= i_r;
    pj_r <= j_r;
    ek_r <= e_r;
  end

  always_comb begin
    dx  = (rd_a_r.x > rd_b_r.x) ? rd_a_r.x - rd_b_r.x : rd_b_r.x - rd_a_r.x;
    dy  = (rd_a_r.y > rd_b_r.y) ? rd_a_r.y - rd_b_r.y : rd_b_r.y - rd_a_r.y;
    dx2 = dx * dx;
    dy2 = dy * dy;
    dsq = {1'b0, dx2} + {1'b0, dy2};
    close_pair = pv_r && !rd_a_r.bif && !rd_b_r.bif && (dsq < min_distance_sq);
  end

  always_comb begin
    mark_set = '0;
    if (close_pair) begin
      mark_set[pi_r] = 1'b1;
      mark_set[pj_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r    <= '0;
      mark_r <= '0;
      pv_r   <= 1'b0;
      ev_r   <= 1'b0;
    end else begin
      pv_r <= cmd.pair_run;
      ev_r <= cmd.emit_run;
      if (cmd.send_centroid) begin
        n_r    <= '0;
        mark_r <= '0;
      end else begin
        if (cmd.load && !full) begin
          n_r <= n_r + CW'(1);
        end
        mark_r <= mark_r | mark_set;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      rid_sx_r  <= '0;
      rid_sy_r  <= '0;
      bif_sx_r  <= '0;
      bif_sy_r  <= '0;
      rid_n_r   <= '0;
      bif_n_r   <= '0;
      removed_r <= '0;
    end else if (ev_r) begin
      if (mark_r[ek_r]) begin
        removed_r <= removed_r + CW'(1);
      end else if (rd_a_r.bif) begin
        bif_sx_r <= bif_sx_r + SW'(rd_a_r.x);
        bif_sy_r <= bif_sy_r + SW'(rd_a_r.y);
        bif_n_r  <= bif_n_r + CW'(1);
      end else begin
        rid_sx_r <= rid_sx_r + SW'(rd_a_r.x);
        rid_sy_r <= rid_sy_r + SW'(rd_a_r.y);
        rid_n_r  <= rid_n_r + CW'(1);
      end
    end
  end

  always_comb begin
    use_bif = (bif_n_r != '0) && (bif_n_r < rid_n_r);
    cnt     = use_bif ? bif_n_r : rid_n_r;
    cnt_nz  = cnt != '0;
    if (cmd.div_sel_y) begin
      div_num = use_bif ? bif_sy_r : rid_sy_r;
    end else begin
      div_num = use_bif ? bif_sx_r : rid_sx_r;
    end
  end

  mpf_divider #(
    .DW(SW),
    .VW(CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.div_go),
    .dividend (div_num),
    .divisor  (cnt),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch_q) begin
      if (cmd.div_sel_y) begin
        qy_r <= div_q[COORD_W-1:0];
      end else begin
        qx_r <= div_q[COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.send_centroid || (ev_r && !mark_r[ek_r]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.send_centroid) begin
      out_data_r.result_kind     <= 1'b1;
      out_data_r.out_x           <= cnt_nz ? qx_r : '0;
      out_data_r.out_y           <= cnt_nz ? qy_r : '0;
      out_data_r.out_bifurcation <= cnt_nz && use_bif;
      out_data_r.centroid_valid  <= cnt_nz;
      out_data_r.removed_count   <= REMOVED_W'(removed_r);
      out_data_r.last_result     <= 1'b1;
    end else begin
      out_data_r.result_kind     <= 1'b0;
      out_data_r.out_x           <= rd_a_r.x;
      out_data_r.out_y           <= rd_a_r.y;
      out_data_r.out_bifurcation <= rd_a_r.bif;
      out_data_r.centroid_valid  <= 1'b0;
      out_data_r.removed_count   <= '0;
      out_data_r.last_result     <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/core/mpf_ctrl.sv
// Controller: sequences load, pair pass, emit pass, centroid divisions and summary.
module mpf_ctrl
  import mpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        in_last,
  input  mpf_status_t status,
  output mpf_cmd_t    cmd,
  output logic        busy
);

  mpf_state_t state_r;
  mpf_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && in_last) state_nxt = ST_PAIR;
      end
      ST_PAIR: begin
        if (status.n_lt2 || status.pair_last) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.emit_last) state_nxt = ST_EMIT_DRAIN;
      end
      ST_EMIT_DRAIN: state_nxt = ST_DIVX_GO;
      ST_DIVX_GO:    state_nxt = ST_DIVX_WAIT;
      ST_DIVX_WAIT: begin
        if (status.div_done) state_nxt = ST_DIVY_GO;
      end
      ST_DIVY_GO:    state_nxt = ST_DIVY_WAIT;
      ST_DIVY_WAIT: begin
        if (status.div_done) state_nxt = ST_CENTROID;
      end
      ST_CENTROID:   state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.init = 1'b1;
        cmd.load = start;
      end
      ST_PAIR:       cmd.pair_run = !status.n_lt2;
      ST_EMIT:       cmd.emit_run = 1'b1;
      ST_EMIT_DRAIN: cmd = '0;
      ST_DIVX_GO:    cmd.div_go = 1'b1;
      ST_DIVX_WAIT:  cmd.latch_q = status.div_done;
      ST_DIVY_GO: begin
        cmd.div_go    = 1'b1;
        cmd.div_sel_y = 1'b1;
      end
      ST_DIVY_WAIT: begin
        cmd.div_sel_y = 1'b1;
        cmd.latch_q   = status.div_done;
      end
      ST_CENTROID:   cmd.send_centroid = 1'b1;
      default:       cmd = '0;
    endcase
  end

endmodule

### test/mpf_checker.sv
// Checker: predicts the filter's output beats from observed inputs and compares them.
`timescale 1ns / 100ps

module mpf_checker
  import mpf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  mpf_in_t               in_data,
  input  logic                  out_valid,
  input  mpf_out_t              out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output int                    errors,
  output int                    awaited
);

  mpf_entry_t       held [MAX_MINUTIAE_DEF];
  int unsigned      held_n;
  logic [DSQ_W-1:0] min_dsq;
  mpf_out_t         awaited_beats [$];

  initial errors = 0;
  initial awaited = 0;

  task automatic report(input string msg);
    $display("ERROR t=%0t %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      report($sformatf("%s: got %0h, expected %0h", name, got, want));
    end
  endtask

  // Mark close ridge-ending pairs, queue survivors in load order, then the centroid.
  task automatic filter_held_set();
    logic        marked [MAX_MINUTIAE_DEF];
    int unsigned rid_n, bif_n, removed, rid_sx, rid_sy, bif_sx, bif_sy;
    int unsigned cnt, sx, sy, dx, dy;
    logic        from_bif;
    mpf_out_t    beat;
    rid_n = 0; bif_n = 0; removed = 0;
    rid_sx = 0; rid_sy = 0; bif_sx = 0; bif_sy = 0;
    for (int i = 0; i < MAX_MINUTIAE_DEF; i++) marked[i] = 1'b0;
    for (int i = 0; i < int'(held_n); i++) begin
      if (!held[i].bif) begin
        for (int j = i + 1; j < int'(held_n); j++) begin
          if (!held[j].bif) begin
            dx = (held[i].x > held[j].x) ? held[i].x - held[j].x : held[j].x - held[i].x;
            dy = (held[i].y > held[j].y) ? held[i].y - held[j].y : held[j].y - held[i].y;
            if (dx * dx + dy * dy < min_dsq) begin
              marked[i] = 1'b1;
              marked[j] = 1'b1;
            end
          end
        end
      end
    end
    for (int i = 0; i < int'(held_n); i++) begin
      if (marked[i]) begin
        removed++;
      end else begin
        if (held[i].bif) begin
          bif_sx += held[i].x; bif_sy += held[i].y; bif_n++;
        end else begin
          rid_sx += held[i].x; rid_sy += held[i].y; rid_n++;
        end
        beat = '0;
        beat.out_x = held[i].x;
        beat.out_y = held[i].y;
        beat.out_bifurcation = held[i].bif;
        awaited_beats = {awaited_beats, beat};
      end
    end
    if (bif_n < rid_n && bif_n != 0) begin
      cnt = bif_n; sx = bif_sx; sy = bif_sy; from_bif = 1'b1;
    end else begin
      cnt = rid_n; sx = rid_sx; sy = rid_sy; from_bif = 1'b0;
    end
    beat = '0;
    beat.result_kind = 1'b1;
    beat.last_result = 1'b1;
    beat.removed_count = REMOVED_W'(removed);
    if (cnt != 0) begin
      beat.out_x = COORD_W'(sx / cnt);
      beat.out_y = COORD_W'(sy / cnt);
      beat.out_bifurcation = from_bif;
      beat.centroid_valid = 1'b1;
    end
    awaited_beats = {awaited_beats, beat};
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held_n = 0;
      min_dsq = MIN_DIST_SQ_RST;
      awaited_beats.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[CFG_ADDR_W-1:2] == REG_MIN_DIST_SQ) begin
        min_dsq = pwdata[DSQ_W-1:0];
      end
      if (start && !busy) begin
        if (held_n < MAX_MINUTIAE_DEF) begin
          held[held_n] = '{x: in_data.loc_x, y: in_data.loc_y, bif: in_data.is_bifurcation};
          held_n++;
        end
        if (in_data.last_in_set) begin
          filter_held_set();
          held_n = 0;
        end
      end
      if (out_valid) begin
        if (awaited_beats.size() == 0) begin
          report($sformatf("unexpected beat %0h", out_data));
        end else begin
          check_field("result_kind", out_data.result_kind, awaited_beats[0].result_kind);
          check_field("out_x", out_data.out_x, awaited_beats[0].out_x);
          check_field("out_y", out_data.out_y, awaited_beats[0].out_y);
          check_field("out_bifurcation", out_data.out_bifurcation,
                      awaited_beats[0].out_bifurcation);
          check_field("centroid_valid", out_data.centroid_valid,
                      awaited_beats[0].centroid_valid);
          check_field("removed_count", out_data.removed_count, awaited_beats[0].removed_count);
          check_field("last_result", out_data.last_result, awaited_beats[0].last_result);
          void'(awaited_beats.pop_front());
        end
      end
    end
    awaited <= awaited_beats.size();
  end

endmodule

### test/testbench.sv
// Testbench top: drives minutia sets and threshold writes into the filter and gives the verdict.
`timescale 1ns / 100ps

module testbench;
  import mpf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  mpf_in_t               in_data = '0;
  logic                  out_valid;
  mpf_out_t              out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    errors;
  int                    awaited;
  int                    cycles = 0;
  logic                  burst = 1'b0;

  minutiae_proximity_filter_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  mpf_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .pready   (pready),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .errors   (errors),
    .awaited  (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_minutia(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic bif, input logic last);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= mpf_in_t'{loc_x: x, loc_y: y, is_bifurcation: bif, last_in_set: last};
    do @(posedge clk); while (busy);
  endtask

  // Hold off until every awaited beat is out and the block is idle, then write the threshold.
  task automatic set_min_dsq(input logic [DSQ_W-1:0] value);
    start <= 1'b0;
    do @(posedge clk); while (awaited != 0);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_MIN_DIST_SQ, 2'b00};
    pwdata <= CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    int               n_sent;
    int               set_idx;
    int               len;
    int               bif_pct;
    logic             clustered;
    logic [COORD_W-1:0] bx, by, x, y;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // close pair removed, one bifurcation vs one ridge ending
    send_minutia(10'd0, 10'd0, 1'b0, 1'b0);
    send_minutia(10'd9, 10'd0, 1'b0, 1'b0);
    send_minutia(10'd1023, 10'd1023, 1'b1, 1'b0);
    send_minutia(10'd1023, 10'd0, 1'b0, 1'b1);
    // lone bifurcation: empty chosen group
    send_minutia(10'd5, 10'd5, 1'b1, 1'b1);
    // every ridge ending removed
    send_minutia(10'd100, 10'd100, 1'b0, 1'b0);
    send_minutia(10'd100, 10'd109, 1'b0, 1'b0);
    send_minutia(10'd100, 10'd110, 1'b0, 1'b0);
    send_minutia(10'd512, 10'd512, 1'b1, 1'b1);
    // bifurcation centroid, pair exactly at the threshold kept
    burst = 1'b1;
    send_minutia(10'd10, 10'd20, 1'b0, 1'b0);
    send_minutia(10'd500, 10'd600, 1'b0, 1'b0);
    send_minutia(10'd1000, 10'd30, 1'b0, 1'b0);
    send_minutia(10'd7, 10'd900, 1'b1, 1'b0);
    send_minutia(10'd300, 10'd300, 1'b0, 1'b0);
    send_minutia(10'd306, 10'd308, 1'b0, 1'b0);
    send_minutia(10'd1023, 10'd1023, 1'b1, 1'b1);
    burst = 1'b0;
    // zero threshold keeps identical points
    set_min_dsq('0);
    send_minutia(10'd200, 10'd200, 1'b0, 1'b0);
    send_minutia(10'd200, 10'd200, 1'b0, 1'b1);
    // top threshold removes all three points; the farthest pair, exactly at it, is not close
    set_min_dsq(21'd2093058);
    send_minutia(10'd0, 10'd0, 1'b0, 1'b0);
    send_minutia(10'd1023, 10'd1023, 1'b0, 1'b0);
    send_minutia(10'd0, 10'd1023, 1'b0, 1'b1);

    n_sent = 0;
    set_idx = 0;
    while (n_sent < 255) begin
      if (set_idx % 5 == 0) begin
        case ($urandom_range(0, 3))
          0: set_min_dsq(DSQ_W'($urandom_range(0, 300)));
          1: set_min_dsq(DSQ_W'($urandom_range(0, 4000)));
          2: set_min_dsq(DSQ_W'($urandom_range(0, 2093058)));
          default: set_min_dsq(MIN_DIST_SQ_RST);
        endcase
      end
      if (set_idx == 0 || $urandom_range(0, 19) == 0) begin
        len = $urandom_range(33, 36);
      end else if ($urandom_range(0, 4) == 0) begin
        len = $urandom_range(13, 32);
      end else begin
        len = $urandom_range(1, 12);
      end
      bif_pct = $urandom_range(0, 100);
      burst = ($urandom_range(0, 3) == 0);
      clustered = ($urandom_range(0, 2) != 0);
      bx = COORD_W'($urandom_range(0, 1023));
      by = COORD_W'($urandom_range(0, 1023));
      for (int k = 0; k < len; k++) begin
        if (clustered) begin
          x = bx ^ COORD_W'($urandom_range(0, 15));
          y = by ^ COORD_W'($urandom_range(0, 15));
        end else begin
          x = COORD_W'($urandom_range(0, 1023));
          y = COORD_W'($urandom_range(0, 1023));
        end
        send_minutia(x, y, ($urandom_range(0, 99) < bif_pct), (k == len - 1));
      end
      n_sent += len;
      set_idx++;
    end
    start <= 1'b0;

    do @(posedge clk); while (awaited != 0);
    repeat (50) @(posedge clk);
    if (errors == 0 && awaited == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
